FILE: src/irhmc_pkg.sv
// Shared constants, codes and types of the gyro rate history block.
package irhmc_pkg;

    localparam int HISTORY_DEPTH_DEFAULT = 80;

    localparam int STAMP_W = 32;
    localparam int RATE_W  = 17;
    localparam int LIMIT_W = 16;
    localparam int LOOK_W  = 7;
    localparam int REQ_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_STORE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_HEAD  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BODY  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BODY_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOKBACK   = 2'd2;

    typedef struct packed {
        logic [STAMP_W-1:0]       stamp;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
    } entry_t;

    typedef struct packed {
        logic store;
        logic start;
        logic scan;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

endpackage

FILE: src/irhmc_if.sv
// Valid/ready channel interfaces for request and result beats.
interface irhmc_req_if
    import irhmc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [REQ_W-1:0]         req_type;
    logic [STAMP_W-1:0]       stamp;
    logic signed [RATE_W-1:0] rate_x;
    logic signed [RATE_W-1:0] rate_y;
    logic signed [RATE_W-1:0] rate_z;

    modport source (output valid, req_type, stamp, rate_x, rate_y, rate_z, input ready);
    modport sink (input valid, req_type, stamp, rate_x, rate_y, rate_z, output ready);
endinterface

interface irhmc_rsp_if;
    logic valid;
    logic ready;
    logic too_fast;
    logic no_bracket;

    modport source (output valid, too_fast, no_bracket, input ready);
    modport sink (input valid, too_fast, no_bracket, output ready);
endinterface

FILE: src/irhmc_dp.sv
// Datapath: history memory, configuration registers and the scan evaluation.
module irhmc_dp
    import irhmc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_W-1:0]     cfg_idx,
    input  logic [CFG_DATA_W-1:0]    cfg_data,
    input  logic [REQ_W-1:0]         req_type,
    input  logic [STAMP_W-1:0]       stamp,
    input  logic signed [RATE_W-1:0] rate_x,
    input  logic signed [RATE_W-1:0] rate_y,
    input  logic signed [RATE_W-1:0] rate_z,
    input  cmd_t                     cmd,
    output status_t                  status,
    output logic                     too_fast,
    output logic                     no_bracket
);

    localparam int IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int DIFF_W = CW + LOOK_W;

    entry_t mem [HISTORY_DEPTH];
    entry_t rd_data_reg;

    logic [LIMIT_W-1:0] head_limit_reg;
    logic [LIMIT_W-1:0] body_limit_reg;
    logic [LOOK_W-1:0]  lookback_reg;

    logic [IW-1:0] oldest_reg;
    logic [CW-1:0] fill_reg;

    logic [STAMP_W-1:0] query_reg;
    logic               body_reg;
    logic [IW-1:0]      rd_slot_reg;
    logic [CW-1:0]      issue_idx_reg;
    logic               eval_valid_reg;
    logic [CW-1:0]      eval_idx_reg;
    logic               prev_over_reg;
    logic               hit_valid_reg;
    logic [CW-1:0]      hit_idx_reg;
    logic               pend_fast_reg;
    logic               pend_nb_reg;

    logic [IW:0]        slot_sum;
    logic [IW-1:0]      wr_slot;
    logic [IW-1:0]      rd_slot_inc;
    logic [IW-1:0]      oldest_inc;
    logic [RATE_W-1:0]  mag_y;
    logic [RATE_W-1:0]  mag_z;
    logic               over;
    logic               hit;
    logic               at_or_after;
    logic               after;
    logic               first;
    logic               last;
    logic               lb_mode;
    logic               in_window;
    logic [CW-1:0]      hit_dist;
    logic               res_fast;
    logic               res_nb;

    assign slot_sum = (IW+1)'(oldest_reg) + (IW+1)'(fill_reg);
    assign wr_slot  = (fill_reg < CW'(HISTORY_DEPTH))
                    ? ((slot_sum >= (IW+1)'(HISTORY_DEPTH))
                       ? IW'(slot_sum - (IW+1)'(HISTORY_DEPTH)) : IW'(slot_sum))
                    : oldest_reg;
    assign rd_slot_inc = (rd_slot_reg == IW'(HISTORY_DEPTH - 1)) ? '0 : rd_slot_reg + 1'b1;
    assign oldest_inc  = (oldest_reg == IW'(HISTORY_DEPTH - 1)) ? '0 : oldest_reg + 1'b1;

    assign mag_y = rd_data_reg.rate_y[RATE_W-1] ? RATE_W'(-rd_data_reg.rate_y)
                                                : RATE_W'(rd_data_reg.rate_y);
    assign mag_z = rd_data_reg.rate_z[RATE_W-1] ? RATE_W'(-rd_data_reg.rate_z)
                                                : RATE_W'(rd_data_reg.rate_z);
    assign over  = body_reg ? (mag_z > RATE_W'(body_limit_reg))
                            : (mag_y > RATE_W'(head_limit_reg));
    assign hit   = over && (rd_data_reg.rate_x != '0) && (rd_data_reg.rate_y != '0)
                 && (rd_data_reg.rate_z != '0);

    assign at_or_after = rd_data_reg.stamp >= query_reg;
    assign after       = rd_data_reg.stamp > query_reg;
    assign first       = eval_idx_reg == '0;
    assign last        = (eval_idx_reg + 1'b1) == fill_reg;
    assign lb_mode     = lookback_reg != '0;
    assign hit_dist    = eval_idx_reg - hit_idx_reg;
    assign in_window   = hit_valid_reg && (DIFF_W'(hit_dist) < DIFF_W'(lookback_reg));

    always_comb
    begin
        status.done = 1'b0;
        res_fast    = 1'b0;
        res_nb      = 1'b0;
        if (cmd.scan && fill_reg == '0)
        begin
            status.done = 1'b1;
            res_fast    = !lb_mode;
            res_nb      = !lb_mode;
        end
        else if (eval_valid_reg)
        begin
            if (!lb_mode)
            begin
                if (!first && at_or_after)
                begin
                    status.done = 1'b1;
                    res_fast    = prev_over_reg || over;
                end
                else if (last)
                begin
                    status.done = 1'b1;
                    res_fast    = 1'b1;
                    res_nb      = 1'b1;
                end
            end
            else
            begin
                if (first && after && hit)
                begin
                    status.done = 1'b1;
                    res_fast    = 1'b1;
                end
                else if (first && !after && rd_data_reg.stamp == '0)
                begin
                    status.done = 1'b1;
                end
                else if (!first && at_or_after)
                begin
                    status.done = 1'b1;
                    res_fast    = hit || in_window;
                end
                else if (last)
                begin
                    status.done = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store)
        begin
            mem[wr_slot] <= '{stamp: stamp, rate_x: rate_x, rate_y: rate_y, rate_z: rate_z};
        end
        rd_data_reg <= mem[rd_slot_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_limit_reg <= '0;
            body_limit_reg <= '0;
            lookback_reg   <= '0;
            oldest_reg     <= '0;
            fill_reg       <= '0;
            eval_valid_reg <= 1'b0;
            hit_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_HEAD_LIMIT: head_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_BODY_LIMIT: body_limit_reg <= cfg_data[LIMIT_W-1:0];
                    CFG_LOOKBACK:   lookback_reg   <= cfg_data[LOOK_W-1:0];
                    default:        ;
                endcase
            end
            if (cmd.store)
            begin
                if (fill_reg < CW'(HISTORY_DEPTH))
                begin
                    fill_reg <= fill_reg + 1'b1;
                end
                else
                begin
                    oldest_reg <= oldest_inc;
                end
            end
            if (cmd.start)
            begin
                eval_valid_reg <= 1'b0;
                hit_valid_reg  <= 1'b0;
            end
            else
            begin
                eval_valid_reg <= cmd.scan && (issue_idx_reg < fill_reg) && !status.done;
                if (eval_valid_reg && hit)
                begin
                    hit_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            query_reg     <= stamp;
            body_reg      <= (req_type == REQ_BODY);
            rd_slot_reg   <= oldest_reg;
            issue_idx_reg <= '0;
        end
        else if (cmd.scan)
        begin
            rd_slot_reg   <= rd_slot_inc;
            issue_idx_reg <= (issue_idx_reg < fill_reg) ? issue_idx_reg + 1'b1 : issue_idx_reg;
        end
        eval_idx_reg <= issue_idx_reg;
        if (eval_valid_reg)
        begin
            prev_over_reg <= over;
            if (hit)
            begin
                hit_idx_reg <= eval_idx_reg;
            end
        end
        if (status.done)
        begin
            pend_fast_reg <= res_fast;
            pend_nb_reg   <= res_nb;
        end
        if (cmd.load_out)
        begin
            too_fast   <= pend_fast_reg;
            no_bracket <= pend_nb_reg;
        end
    end

endmodule

FILE: src/irhmc_ctrl.sv
// Controller: sequences stores, history scans and the result beat.
module irhmc_ctrl
    import irhmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic [REQ_W-1:0] req_type,
    output logic             req_ready,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    input  status_t          status,
    output cmd_t             cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;
    logic   is_check;

    assign is_check  = (req_type == REQ_HEAD) || (req_type == REQ_BODY);
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd.store    = (state_reg == S_IDLE) && req_valid && (req_type == REQ_STORE);
        cmd.start    = (state_reg == S_IDLE) && req_valid && is_check;
        cmd.scan     = (state_reg == S_SCAN);
        cmd.load_out = (state_reg == S_HOLD) && (!rsp_valid_reg || rsp_ready);

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (status.done)
                begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                if (cmd.load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: src/imu_rate_history_motion_check_top.sv
// Top level of the gyro rate history block with head and body motion checks.
// A store beat writes the sample into a ring of HISTORY_DEPTH entries held in
// a single memory; a check beat scans that memory from the oldest entry
// forward, one entry per cycle through its one registered read port, and stops
// at the first later entry at or after the queried time or at the newest entry
// (with a lookback set, it may also stop at the oldest). Each read entry is
// evaluated, the verdict is latched in a pending register and then loaded into
// the output register, where the result beat is offered. The result sits
// there, and stores are taken while it waits to be accepted; a later check
// that finishes while it still waits stalls the input.
module imu_rate_history_motion_check_top
    import irhmc_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    irhmc_req_if.sink             req,
    irhmc_rsp_if.source           rsp
);

    cmd_t    cmd;
    status_t status;

    irhmc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_type  (req.req_type),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    irhmc_dp #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_idx    (cfg_idx),
        .cfg_data   (cfg_data),
        .req_type   (req.req_type),
        .stamp      (req.stamp),
        .rate_x     (req.rate_x),
        .rate_y     (req.rate_y),
        .rate_z     (req.rate_z),
        .cmd        (cmd),
        .status     (status),
        .too_fast   (rsp.too_fast),
        .no_bracket (rsp.no_bracket)
    );

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the gyro rate history block: stores, head and body checks.
module tb_top
    import irhmc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH         = HISTORY_DEPTH_DEFAULT;
    localparam int SETTLE_CYCLES = 2 * DEPTH;
    localparam int HOLD_CYCLES   = 600;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 250;
    localparam int PHASES        = 7;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam logic signed [RATE_W-1:0] RATE_MIN = {1'b1, {(RATE_W-1){1'b0}}};
    localparam logic signed [RATE_W-1:0] RATE_MAX = {1'b0, {(RATE_W-1){1'b1}}};
    localparam logic signed [RATE_W-1:0] RATE_ONE = RATE_W'(1);
    localparam logic signed [RATE_W-1:0] RATE_NIL = RATE_W'(0);

    localparam int PH_HEAD [PHASES] = '{1000, 100, 65535, 500, 65535, 0, 0};
    localparam int PH_BODY [PHASES] = '{1000, 200, 65535, 300, 0, 0, 0};
    localparam int PH_LOOK [PHASES] = '{80, 0, 0, 1, 5, 0, 80};

    typedef struct packed {
        logic [REQ_W-1:0]         req_type;
        logic [STAMP_W-1:0]       stamp;
        logic signed [RATE_W-1:0] rate_x;
        logic signed [RATE_W-1:0] rate_y;
        logic signed [RATE_W-1:0] rate_z;
    } gyro_beat_t;

    typedef struct packed {
        logic too_fast;
        logic no_bracket;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    irhmc_req_if req_ch();
    irhmc_rsp_if rsp_ch();

    imu_rate_history_motion_check_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .req      (req_ch),
        .rsp      (rsp_ch)
    );

    gyro_beat_t         pending_q [$];
    verdict_t           verdict_q [$];
    logic [STAMP_W-1:0] recent_stamps [$];
    logic [STAMP_W-1:0] next_stamp = '0;

    logic [STAMP_W-1:0]       hist_stamp [DEPTH];
    logic signed [RATE_W-1:0] hist_roll  [DEPTH];
    logic signed [RATE_W-1:0] hist_pitch [DEPTH];
    logic signed [RATE_W-1:0] hist_yaw   [DEPTH];
    int unsigned              hist_oldest = 0;
    int unsigned              hist_fill   = 0;

    logic [LIMIT_W-1:0] head_limit   = '0;
    logic [LIMIT_W-1:0] body_limit   = '0;
    logic [LOOK_W-1:0]  lookback_len = '0;

    int send_gap;
    int sink_gap;
    int hold_cnt;
    int hold_served;
    int hold_requested = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    bit calm           = 1'b0;

    function automatic int unsigned slot_at(int unsigned pos);
        return (hist_oldest + pos) % DEPTH;
    endfunction

    function automatic logic [RATE_W:0] rate_mag(logic signed [RATE_W-1:0] r);
        logic signed [RATE_W:0] w;
        w = (RATE_W+1)'(r);
        return (w < 0) ? -w : w;
    endfunction

    function automatic bit axis_over(int unsigned pos, bit body);
        int unsigned s;
        s = slot_at(pos);
        if (body)
            return rate_mag(hist_yaw[s]) > body_limit;
        return rate_mag(hist_pitch[s]) > head_limit;
    endfunction

    function automatic bit triple_hit(int unsigned pos, bit body);
        int unsigned        s;
        logic [LIMIT_W-1:0] ly;
        logic [LIMIT_W-1:0] lz;
        s  = slot_at(pos);
        ly = body ? '0 : head_limit;
        lz = body ? body_limit : '0;
        return rate_mag(hist_roll[s]) != 0 && rate_mag(hist_pitch[s]) > ly
            && rate_mag(hist_yaw[s]) > lz;
    endfunction

    function automatic bit lookback_scan(logic [STAMP_W-1:0] t, bit body);
        int unsigned p;
        int unsigned i;
        int unsigned n;
        if (hist_fill == 0)
            return 1'b0;
        if (hist_stamp[slot_at(0)] > t)
        begin
            if (triple_hit(0, body))
                return 1'b1;
        end
        else if (hist_stamp[slot_at(0)] == 0)
        begin
            return 1'b0;
        end
        for (p = 1; p < hist_fill; p++)
        begin
            if (hist_stamp[slot_at(p)] >= t)
            begin
                i = p;
                for (n = 0; n < lookback_len; n++)
                begin
                    if (triple_hit(i, body))
                        return 1'b1;
                    if (i == 0)
                        return 1'b0;
                    i--;
                end
                return 1'b0;
            end
        end
        return 1'b0;
    endfunction

    function automatic void apply_gyro_beat(gyro_beat_t b);
        int unsigned s;
        int unsigned p;
        bit          body;
        bit          found;
        verdict_t    v;
        case (b.req_type)
            REQ_STORE:
            begin
                if (hist_fill < DEPTH)
                begin
                    s = slot_at(hist_fill);
                    hist_fill++;
                end
                else
                begin
                    s = hist_oldest;
                    hist_oldest = (hist_oldest + 1) % DEPTH;
                end
                hist_stamp[s] = b.stamp;
                hist_roll[s]  = b.rate_x;
                hist_pitch[s] = b.rate_y;
                hist_yaw[s]   = b.rate_z;
            end
            REQ_HEAD, REQ_BODY:
            begin
                body = (b.req_type == REQ_BODY);
                if (lookback_len != 0)
                begin
                    v.too_fast   = lookback_scan(b.stamp, body);
                    v.no_bracket = 1'b0;
                end
                else
                begin
                    v.too_fast   = 1'b1;
                    v.no_bracket = 1'b1;
                    found = 1'b0;
                    for (p = 1; p < hist_fill && !found; p++)
                    begin
                        if (hist_stamp[slot_at(p)] >= b.stamp)
                        begin
                            v.too_fast   = axis_over(p - 1, body) || axis_over(p, body);
                            v.no_bracket = 1'b0;
                            found = 1'b1;
                        end
                    end
                end
                verdict_q.push_back(v);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic logic signed [RATE_W-1:0] pick_rate(logic [LIMIT_W-1:0] limit);
        int v;
        case ($urandom_range(0, 7))
            0: v = 0;
            1: v = int'(limit);
            2: v = int'(limit) + 1;
            3: v = int'(limit) - 1;
            4: v = int'(RATE_MAX);
            5: v = int'(RATE_MIN);
            6: v = $urandom_range(0, 2 * limit + 2);
            default: v = $urandom;
        endcase
        if (v != int'(RATE_MIN) && $urandom_range(0, 1) == 1)
            v = -v;
        return v[RATE_W-1:0];
    endfunction

    function automatic void plan_beat(logic [REQ_W-1:0] kind, logic [STAMP_W-1:0] stamp,
                                      logic signed [RATE_W-1:0] x, y, z);
        gyro_beat_t b;
        b.req_type = kind;
        b.stamp    = stamp;
        b.rate_x   = x;
        b.rate_y   = y;
        b.rate_z   = z;
        pending_q.push_back(b);
        if (kind == REQ_STORE)
        begin
            recent_stamps.push_back(stamp);
            if (recent_stamps.size() > DEPTH)
                recent_stamps.delete(0);
        end
    endfunction

    task automatic plan_random(input int count);
        int                 made;
        int                 roll;
        logic [STAMP_W-1:0] t;
        made = 0;
        while (made < count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 3)
            begin
                plan_beat(REQ_UNUSED, $urandom, RATE_W'($urandom), RATE_W'($urandom),
                          RATE_W'($urandom));
            end
            else if (roll < 55)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 3)
                begin
                    t = '0;
                end
                else if (roll < 8)
                begin
                    t = $urandom;
                end
                else if (roll < 10)
                begin
                    next_stamp = $urandom;
                    t = next_stamp;
                end
                else
                begin
                    next_stamp = next_stamp + $urandom_range(0, 20);
                    t = next_stamp;
                end
                plan_beat(REQ_STORE, t, pick_rate(head_limit), pick_rate(head_limit),
                          pick_rate(body_limit));
                made++;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (recent_stamps.size() == 0 || roll < 20)
                    t = $urandom;
                else if (roll < 55)
                    t = recent_stamps[$urandom_range(0, recent_stamps.size() - 1)];
                else if (roll < 70)
                    t = recent_stamps[$urandom_range(0, recent_stamps.size() - 1)] + 1;
                else if (roll < 82)
                    t = recent_stamps[0] - $urandom_range(1, 50);
                else if (roll < 90)
                    t = recent_stamps[$] + $urandom_range(1, 50);
                else if (roll < 95)
                    t = '0;
                else
                    t = '1;
                plan_beat(($urandom_range(0, 1) == 1) ? REQ_BODY : REQ_HEAD, t,
                          RATE_W'($urandom), RATE_W'($urandom), RATE_W'($urandom));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0 || verdict_q.size() != 0 || req_ch.valid)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reconfigure(input logic [LIMIT_W-1:0] head, body,
                               input logic [LOOK_W-1:0] depth_back);
        wait_drained();
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_HEAD_LIMIT;
        cfg_data <= head;
        @(posedge clk);
        cfg_idx  <= CFG_BODY_LIMIT;
        cfg_data <= body;
        @(posedge clk);
        cfg_idx  <= CFG_LOOKBACK;
        cfg_data <= CFG_DATA_W'(depth_back);
        @(posedge clk);
        cfg_we <= 1'b0;
        head_limit   = head;
        body_limit   = body;
        lookback_len = depth_back;
        @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cfg_we   = 1'b0;
        cfg_idx  = '0;
        cfg_data = '0;
        rst_n   <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        reconfigure(16'd0, 16'd0, 7'd3);
        plan_beat(REQ_HEAD, 32'd100, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_BODY, 32'd0, RATE_NIL, RATE_NIL, RATE_NIL);

        reconfigure(16'd0, 16'd0, 7'd0);
        plan_beat(REQ_HEAD, 32'd0, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_STORE, 32'd2, RATE_ONE, RATE_ONE, RATE_ONE);
        plan_beat(REQ_HEAD, 32'd0, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_STORE, 32'd10, RATE_NIL, RATE_MIN, RATE_MAX);
        plan_beat(REQ_HEAD, 32'd5, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_UNUSED, '1, RATE_MIN, RATE_MAX, RATE_MIN);
        plan_beat(REQ_STORE, '1, RATE_MAX, RATE_NIL, RATE_MIN);
        plan_beat(REQ_BODY, '1, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_HEAD, 32'd11, RATE_NIL, RATE_NIL, RATE_NIL);

        reconfigure(16'hFFFF, 16'hFFFF, 7'd0);
        plan_beat(REQ_HEAD, 32'd5, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_BODY, 32'd5, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_BODY, '1, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_HEAD, 32'd11, RATE_NIL, RATE_NIL, RATE_NIL);

        reconfigure(16'd10, 16'd10, 7'd80);
        plan_beat(REQ_HEAD, 32'd1, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_BODY, '1, RATE_NIL, RATE_NIL, RATE_NIL);
        plan_beat(REQ_HEAD, 32'd3, RATE_NIL, RATE_NIL, RATE_NIL);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 5)
                reconfigure(LIMIT_W'($urandom_range(0, 65535)),
                            LIMIT_W'($urandom_range(0, 65535)),
                            LOOK_W'($urandom_range(0, 80)));
            else
                reconfigure(LIMIT_W'(PH_HEAD[ph]), LIMIT_W'(PH_BODY[ph]),
                            LOOK_W'(PH_LOOK[ph]));
            if (ph == PHASES - 1)
                calm = 1'b1;
            plan_random(PHASE_ITEMS);
            if (ph == 1 || ph == 4)
                hold_requested = hold_requested + 1;
        end

        wait_drained();
        if (mismatch_count == 0 && verdict_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin : beat_driver
        gyro_beat_t head_beat;
        if (!rst_n)
        begin
            req_ch.valid    <= 1'b0;
            req_ch.req_type <= REQ_STORE;
            req_ch.stamp    <= '0;
            req_ch.rate_x   <= '0;
            req_ch.rate_y   <= '0;
            req_ch.rate_z   <= '0;
            send_gap        <= 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                apply_gyro_beat(pending_q[0]);
                pending_q.delete(0);
            end
            if (!(req_ch.valid && !req_ch.ready))
            begin
                if (send_gap != 0)
                begin
                    send_gap     <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end
                else if (!calm && $urandom_range(0, 11) == 0)
                begin
                    send_gap     <= $urandom_range(0, 17);
                    req_ch.valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    head_beat = pending_q[0];
                    req_ch.valid    <= 1'b1;
                    req_ch.req_type <= head_beat.req_type;
                    req_ch.stamp    <= head_beat.stamp;
                    req_ch.rate_x   <= head_beat.rate_x;
                    req_ch.rate_y   <= head_beat.rate_y;
                    req_ch.rate_z   <= head_beat.rate_z;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cnt    <= 0;
            hold_served <= 0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
        end
        else if (hold_served != hold_requested)
        begin
            hold_cnt    <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        verdict_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            sink_gap     <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (verdict_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, actual %0b/%0b",
                             $time, rsp_ch.too_fast, rsp_ch.no_bracket);
                    mismatch_count++;
                end
                else
                begin
                    want = verdict_q[0];
                    verdict_q.delete(0);
                    if (rsp_ch.too_fast !== want.too_fast)
                    begin
                        $display("%0t: too_fast mismatch, expected %0b, actual %0b",
                                 $time, want.too_fast, rsp_ch.too_fast);
                        mismatch_count++;
                    end
                    if (rsp_ch.no_bracket !== want.no_bracket)
                    begin
                        $display("%0t: no_bracket mismatch, expected %0b, actual %0b",
                                 $time, want.no_bracket, rsp_ch.no_bracket);
                        mismatch_count++;
                    end
                end
            end
            if (hold_cnt != 0)
            begin
                rsp_ch.ready <= 1'b0;
            end
            else if (sink_gap != 0)
            begin
                sink_gap     <= sink_gap - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                sink_gap     <= $urandom_range(0, 17);
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

endmodule

FILE: sim.f
src/irhmc_pkg.sv
src/irhmc_if.sv
src/irhmc_dp.sv
src/irhmc_ctrl.sv
src/imu_rate_history_motion_check_top.sv
bench/tb_top.sv
